@@ src/vcpd_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vcpd_pkg - shared types and constants for the voxel corner point detector
// Volume limits, buffer address widths, request payload types and the
// register map used by the cells and the top level.
// ============================================================================
package vcpd_pkg;

  // Volume limits and label width
  localparam int MAX_X      = 64;
  localparam int MAX_Y      = 64;
  localparam int MAX_Z      = 64;
  localparam int LABEL_BITS = 16;

  // Field and register widths
  localparam int SIZE_W  = 7;
  localparam int LABEL_W = 16;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  // Coordinate counters
  localparam int X_W = (MAX_X > 1) ? $clog2(MAX_X) : 1;
  localparam int Y_W = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
  localparam int Z_W = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;

  // Line buffers: a row delay is at most MAX_X-1 deep, a plane delay MAX_X*MAX_Y-1
  localparam int PLANE_MAX = MAX_X * MAX_Y;
  localparam int ROW_AW    = X_W;
  localparam int PLANE_AW  = (PLANE_MAX > 1) ? $clog2(PLANE_MAX) : 1;
  localparam int PLANE_W   = $clog2(PLANE_MAX + 1);

  // Fill latency before the first voxel can be judged
  localparam int LAG_MAX = PLANE_MAX + MAX_X + 1;
  localparam int LAG_W   = $clog2(LAG_MAX + 1);

  // Input request
  typedef struct packed {
    logic               func;
    logic [LABEL_W-1:0] voxel_label;
  } in_t;

  // Result request
  typedef struct packed {
    logic [SIZE_W-1:0] pos_x;
    logic [SIZE_W-1:0] pos_y;
    logic [SIZE_W-1:0] pos_z;
    logic              is_member;
    logic              is_corner;
    logic              last;
  } out_t;

  // 3x3 membership taps of one plane, indexed [row][column]
  typedef logic [2:0][2:0] tap_t;

  // Register map (word index)
  typedef enum logic [1:0] {
    REG_CELL_LABEL = 2'd0,
    REG_SIZE_X     = 2'd1,
    REG_SIZE_Y     = 2'd2,
    REG_SIZE_Z     = 2'd3
  } reg_idx_t;

  // Size register to working extent: zero acts as one, clamp at the limit
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s,
                                                 input int lim);
    logic [SIZE_W-1:0] r;
    if (s == '0) begin
      r = SIZE_W'(1);
    end else if (int'(s) > lim) begin
      r = SIZE_W'(lim);
    end else begin
      r = s;
    end
    return r;
  endfunction

endpackage

@@ src/vcpd_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vcpd_ram - single-port line buffer RAM
// Read-before-write at one address per enabled cycle, registered read data.
// ============================================================================
module vcpd_ram #(
  parameter int AW = 6,
  parameter int DW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  // Old contents come out as the new bit goes in
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_r   <= mem[addr];
      mem[addr] <= wdata;
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/vcpd_cell.sv @@
`timescale 1ns / 1ps
// ============================================================================
// vcpd_cell - one plane slice of the 3x3x3 membership window
// Holds three rows of three taps; two row-delay buffers of sx-1 entries
// (plus the read register) space the rows one volume row apart.
// ============================================================================
module vcpd_cell (
  input  logic                        clk,
  input  logic                        adv,
  input  logic                        sx_one,
  input  logic [vcpd_pkg::ROW_AW-1:0] row_ptr,
  input  logic                        bit_in,
  output vcpd_pkg::tap_t              taps
);
  import vcpd_pkg::*;

  logic r0_d1_r, r0_d2_r;
  logic r1_d1_r, r1_d2_r;
  logic r2_d1_r, r2_d2_r;
  logic row1_q, row2_q;
  logic row1_d0, row2_d0;

  // Row delays; a one-voxel row degenerates to a single register
  vcpd_ram #(.AW(ROW_AW), .DW(1)) u_row1 (
    .clk   (clk),
    .en    (adv),
    .addr  (row_ptr),
    .wdata (bit_in),
    .rdata (row1_q)
  );

  assign row1_d0 = sx_one ? r0_d1_r : row1_q;

  vcpd_ram #(.AW(ROW_AW), .DW(1)) u_row2 (
    .clk   (clk),
    .en    (adv),
    .addr  (row_ptr),
    .wdata (row1_d0),
    .rdata (row2_q)
  );

  assign row2_d0 = sx_one ? r1_d1_r : row2_q;

  // Column shift within each row
  always_ff @(posedge clk) begin
    if (adv) begin
      r0_d1_r <= bit_in;
      r0_d2_r <= r0_d1_r;
      r1_d1_r <= row1_d0;
      r1_d2_r <= r1_d1_r;
      r2_d1_r <= row2_d0;
      r2_d2_r <= r2_d1_r;
    end
  end

  // Tap [r][d] is d voxels and r rows older than the slice input
  assign taps[0][0] = bit_in;
  assign taps[0][1] = r0_d1_r;
  assign taps[0][2] = r0_d2_r;
  assign taps[1][0] = row1_d0;
  assign taps[1][1] = r1_d1_r;
  assign taps[1][2] = r1_d2_r;
  assign taps[2][0] = row2_d0;
  assign taps[2][1] = r2_d1_r;
  assign taps[2][2] = r2_d2_r;

endmodule

@@ src/voxel_corner_point_detect_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// voxel_corner_point_detect_unit - streaming corner voxel detector
// Turns a raster-order label stream into membership bits and judges each
// voxel on its 3x3x3 neighborhood held in a chain of three plane slices.
// ============================================================================
// Takes one voxel request per unstalled clock, x fastest, then y, then z, and
// returns one result per voxel in the same order. A voxel is judged in the
// cycle that accepts the voxel sx*sy + sx + 1 positions after it, so after the
// last voxel that many flush requests (func = 1) drain the window; the result
// is registered and shows in the next cycle. Throughput is one request per
// unstalled cycle, set by the single-port line buffers (two plane delays of
// sx*sy-1 entries, six row delays of sx-1 entries) that are read and written
// once per accepted request. Buffers need no clearing pass: neighbors outside
// the volume are masked by coordinate checks. A flush before all voxels have
// arrived is accepted and ignored. Writing a size register restarts the
// volume; write configuration only while no request is pending.
module voxel_corner_point_detect_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // Voxel input
  input  logic                        in_valid,
  output logic                        in_stall,
  input  vcpd_pkg::in_t               in_data,
  // Results
  output logic                        out_valid,
  input  logic                        out_stall,
  output vcpd_pkg::out_t              out_data,
  // Configuration
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [vcpd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [vcpd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [vcpd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import vcpd_pkg::*;

  // Configuration registers
  logic [LABEL_W-1:0] cell_label_r;
  logic [SIZE_W-1:0]  size_x_r, size_y_r, size_z_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;
  logic               size_wr;

  // Working extents
  logic [SIZE_W-1:0]  sx, sy, sz;
  logic [PLANE_W-1:0] plane;
  logic [LAG_W-1:0]   lag;
  logic               sx_one, p_one;

  // Handshake and progress
  logic               accept, adv, produce, mem_bit;
  logic [ROW_AW-1:0]  row_ptr_r, row_ptr_nxt;
  logic [PLANE_AW-1:0] plane_ptr_r, plane_ptr_nxt;
  logic [X_W-1:0]     ix_r, ix_nxt, cx_r, cx_nxt;
  logic [Y_W-1:0]     iy_r, iy_nxt, cy_r, cy_nxt;
  logic [Z_W-1:0]     iz_r, iz_nxt, cz_r, cz_nxt;
  logic               in_done_r, in_done_nxt;
  logic [LAG_W-1:0]   head_cnt_r, head_cnt_nxt;
  logic               ix_end, iy_end, iz_end, cx_end, cy_end, cz_end;

  // Window
  tap_t               taps [3];
  logic               slice_in [3];
  logic               plane_q [2];

  // Judgement
  logic               xl, xh, yl, yh, zl, zh;
  logic [8:0]         pair;
  logic               centre, corner, res_last;

  // Result register
  logic               out_valid_r, out_valid_nxt;
  out_t               out_data_r;

  // --------------------------------------------------------------------------
  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign size_wr    = cfg_wr && (cfg_idx == REG_SIZE_X || cfg_idx == REG_SIZE_Y ||
                                 cfg_idx == REG_SIZE_Z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_label_r <= LABEL_W'(1);
      size_x_r     <= SIZE_W'(64);
      size_y_r     <= SIZE_W'(64);
      size_z_r     <= SIZE_W'(64);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_CELL_LABEL: cell_label_r <= cfg_pwdata[LABEL_W-1:0];
        REG_SIZE_X:     size_x_r     <= cfg_pwdata[SIZE_W-1:0];
        REG_SIZE_Y:     size_y_r     <= cfg_pwdata[SIZE_W-1:0];
        REG_SIZE_Z:     size_z_r     <= cfg_pwdata[SIZE_W-1:0];
        default:        ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_CELL_LABEL: cfg_prdata = CFG_DW'(cell_label_r);
      REG_SIZE_X:     cfg_prdata = CFG_DW'(size_x_r);
      REG_SIZE_Y:     cfg_prdata = CFG_DW'(size_y_r);
      REG_SIZE_Z:     cfg_prdata = CFG_DW'(size_z_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Working extents and fill latency
  assign sx     = eff_size(size_x_r, MAX_X);
  assign sy     = eff_size(size_y_r, MAX_Y);
  assign sz     = eff_size(size_z_r, MAX_Z);
  assign plane  = PLANE_W'(sx) * PLANE_W'(sy);
  assign lag    = LAG_W'(plane) + LAG_W'(sx) + LAG_W'(1);
  assign sx_one = (sx == SIZE_W'(1));
  assign p_one  = (plane == PLANE_W'(1));

  // --------------------------------------------------------------------------
  // Handshake: an early flush is taken but moves nothing
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign adv      = accept && !(in_data.func && !in_done_r);
  assign produce  = adv && (head_cnt_r >= lag);
  assign mem_bit  = (in_data.voxel_label[LABEL_BITS-1:0] ==
                     cell_label_r[LABEL_BITS-1:0]);

  // --------------------------------------------------------------------------
  // Chain of plane slices joined by plane delays
  assign slice_in[0] = mem_bit;

  for (genvar k = 0; k < 3; k++) begin : g_slice
    vcpd_cell u_cell (
      .clk     (clk),
      .adv     (adv),
      .sx_one  (sx_one),
      .row_ptr (row_ptr_r),
      .bit_in  (slice_in[k]),
      .taps    (taps[k])
    );
  end

  for (genvar k = 0; k < 2; k++) begin : g_plane
    vcpd_ram #(.AW(PLANE_AW), .DW(1)) u_plane (
      .clk   (clk),
      .en    (adv),
      .addr  (plane_ptr_r),
      .wdata (slice_in[k]),
      .rdata (plane_q[k])
    );
    assign slice_in[k+1] = p_one ? taps[k][0][1] : plane_q[k];
  end

  // --------------------------------------------------------------------------
  // Coordinate end flags
  assign ix_end = (SIZE_W'(ix_r) == sx - SIZE_W'(1));
  assign iy_end = (SIZE_W'(iy_r) == sy - SIZE_W'(1));
  assign iz_end = (SIZE_W'(iz_r) == sz - SIZE_W'(1));
  assign cx_end = (SIZE_W'(cx_r) == sx - SIZE_W'(1));
  assign cy_end = (SIZE_W'(cy_r) == sy - SIZE_W'(1));
  assign cz_end = (SIZE_W'(cz_r) == sz - SIZE_W'(1));

  // Neighbor inside the volume on each side of the centre
  assign xl = (cx_r != '0);
  assign xh = !cx_end;
  assign yl = (cy_r != '0);
  assign yh = !cy_end;
  assign zl = (cz_r != '0);
  assign zh = !cz_end;

  // Opposite neighbor pairs; tap [1-dz][1-dy][1-dx] sits at offset (dx,dy,dz)
  always_comb begin
    pair[0] = taps[1][1][0] && xh && taps[1][1][2] && xl;                  // x
    pair[1] = taps[1][0][1] && yh && taps[1][2][1] && yl;                  // y
    pair[2] = taps[0][1][1] && zh && taps[2][1][1] && zl;                  // z
    pair[3] = taps[1][0][0] && xh && yh && taps[1][2][2] && xl && yl;      // xy
    pair[4] = taps[1][2][0] && xh && yl && taps[1][0][2] && xl && yh;      // x, -y
    pair[5] = taps[0][0][1] && yh && zh && taps[2][2][1] && yl && zl;      // yz
    pair[6] = taps[2][0][1] && yh && zl && taps[0][2][1] && yl && zh;      // y, -z
    pair[7] = taps[0][1][0] && xh && zh && taps[2][1][2] && xl && zl;      // zx
    pair[8] = taps[2][1][0] && xh && zl && taps[0][1][2] && xl && zh;      // x, -z
  end

  assign centre   = taps[1][1][1];
  assign corner   = centre && !(|pair);
  assign res_last = cx_end && cy_end && cz_end;

  // --------------------------------------------------------------------------
  // Buffer pointers and volume counters
  always_comb begin
    row_ptr_nxt   = row_ptr_r;
    plane_ptr_nxt = plane_ptr_r;
    ix_nxt        = ix_r;
    iy_nxt        = iy_r;
    iz_nxt        = iz_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    in_done_nxt   = in_done_r;
    head_cnt_nxt  = head_cnt_r;

    if (size_wr) begin
      row_ptr_nxt   = '0;
      plane_ptr_nxt = '0;
      ix_nxt        = '0;
      iy_nxt        = '0;
      iz_nxt        = '0;
      cx_nxt        = '0;
      cy_nxt        = '0;
      cz_nxt        = '0;
      in_done_nxt   = 1'b0;
      head_cnt_nxt  = '0;
    end else if (adv) begin
      // Circular row and plane delays
      if (sx_one || (SIZE_W'(row_ptr_r) >= sx - SIZE_W'(2))) begin
        row_ptr_nxt = '0;
      end else begin
        row_ptr_nxt = row_ptr_r + ROW_AW'(1);
      end
      if (p_one || (PLANE_W'(plane_ptr_r) >= plane - PLANE_W'(2))) begin
        plane_ptr_nxt = '0;
      end else begin
        plane_ptr_nxt = plane_ptr_r + PLANE_AW'(1);
      end

      // Input raster position
      if (!in_done_r) begin
        if (ix_end) begin
          ix_nxt = '0;
          if (iy_end) begin
            iy_nxt = '0;
            if (iz_end) begin
              iz_nxt      = '0;
              in_done_nxt = 1'b1;
            end else begin
              iz_nxt = iz_r + Z_W'(1);
            end
          end else begin
            iy_nxt = iy_r + Y_W'(1);
          end
        end else begin
          ix_nxt = ix_r + X_W'(1);
        end
      end

      // Fill count up to the first judgement
      if (head_cnt_r < lag) begin
        head_cnt_nxt = head_cnt_r + LAG_W'(1);
      end

      // Centre raster position; the final voxel starts a new volume
      if (produce) begin
        if (res_last) begin
          cx_nxt       = '0;
          cy_nxt       = '0;
          cz_nxt       = '0;
          ix_nxt       = '0;
          iy_nxt       = '0;
          iz_nxt       = '0;
          in_done_nxt  = 1'b0;
          head_cnt_nxt = '0;
        end else if (cx_end) begin
          cx_nxt = '0;
          if (cy_end) begin
            cy_nxt = '0;
            cz_nxt = cz_r + Z_W'(1);
          end else begin
            cy_nxt = cy_r + Y_W'(1);
          end
        end else begin
          cx_nxt = cx_r + X_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_ptr_r   <= '0;
      plane_ptr_r <= '0;
      ix_r        <= '0;
      iy_r        <= '0;
      iz_r        <= '0;
      cx_r        <= '0;
      cy_r        <= '0;
      cz_r        <= '0;
      in_done_r   <= 1'b0;
      head_cnt_r  <= '0;
    end else begin
      row_ptr_r   <= row_ptr_nxt;
      plane_ptr_r <= plane_ptr_nxt;
      ix_r        <= ix_nxt;
      iy_r        <= iy_nxt;
      iz_r        <= iz_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      cz_r        <= cz_nxt;
      in_done_r   <= in_done_nxt;
      head_cnt_r  <= head_cnt_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  assign out_valid_nxt = produce || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      out_data_r.pos_x     <= SIZE_W'(cx_r) + SIZE_W'(1);
      out_data_r.pos_y     <= SIZE_W'(cy_r) + SIZE_W'(1);
      out_data_r.pos_z     <= SIZE_W'(cz_r) + SIZE_W'(1);
      out_data_r.is_member <= centre;
      out_data_r.is_corner <= corner;
      out_data_r.last      <= res_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Checks

  // The final voxel is judged only after every voxel has arrived
  a_last_after_input: assert property (@(posedge clk) disable iff (!rst_n)
    (produce && res_last) |-> in_done_r)
    else $error("final voxel judged before the volume was complete");

  // Judging the final voxel returns the volume counters to the start
  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (produce && res_last) |=> (head_cnt_r == '0 && !in_done_r && cx_r == '0))
    else $error("volume counters not restarted after final voxel");

  // A corner is always a member of the cell
  a_corner_member: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.is_corner || out_data_r.is_member))
    else $error("corner flagged on a non-member voxel");

endmodule

@@ tb/voxel_corner_point_detect_unit_tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// voxel_corner_point_detect_unit_tb - self-checking bench for the corner detector
// Streams labelled voxel volumes and flush requests, predicts every result
// from an in-bench copy of the membership window and checks the result stream,
// with random sender bursts, receiver stalls and register changes between and within runs.
// ============================================================================
module voxel_corner_point_detect_unit_tb;
  import vcpd_pkg::*;

  localparam int WIN_DEPTH      = 2 * MAX_X * MAX_Y + 2 * MAX_X + 3;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RANDOM_ITEMS   = 300;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_RUNS} stall_mode_t;
  typedef enum {PAUSE_NONE, PAUSE_RELABEL, PAUSE_RESTART} pause_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_t               in_data;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  voxel_corner_point_detect_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted detector state
  logic               win_bits [WIN_DEPTH];
  int                 arrived;
  int                 judged;
  logic [LABEL_W-1:0] sought_label;
  logic [LABEL_W-1:0] prev_label;
  logic [SIZE_W-1:0]  size_x_reg;
  logic [SIZE_W-1:0]  size_y_reg;
  logic [SIZE_W-1:0]  size_z_reg;

  out_t verdict_q [$];
  int   error_count = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   quiet_cycles = 0;
  int   burst_left = 0;
  int   gap_odds = 0;

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endtask

  // Working extent of a size register
  function automatic int extent(input logic [SIZE_W-1:0] s, input int lim);
    if (s == '0) return 1;
    if (int'(s) > lim) return lim;
    return int'(s);
  endfunction

  function automatic int cur_total();
    return extent(size_x_reg, MAX_X) * extent(size_y_reg, MAX_Y) * extent(size_z_reg, MAX_Z);
  endfunction

  function automatic int cur_lag();
    int sx;
    sx = extent(size_x_reg, MAX_X);
    return sx * extent(size_y_reg, MAX_Y) + sx + 1;
  endfunction

  // Membership at 0-based position; outside the volume is never a member
  function automatic logic member_at(input int x, y, z, sx, sy, sz);
    if (x < 0 || y < 0 || z < 0 || x >= sx || y >= sy || z >= sz) return 1'b0;
    return win_bits[((z * sy + y) * sx + x) % WIN_DEPTH];
  endfunction

  function automatic logic both_members(input int x, y, z, dx, dy, dz, sx, sy, sz);
    return member_at(x + dx, y + dy, z + dz, sx, sy, sz) &&
           member_at(x - dx, y - dy, z - dz, sx, sy, sz);
  endfunction

  // Take one accepted request into the window; returns 1 with a verdict when
  // a voxel gets judged
  function automatic bit advance_window(input in_t item, output out_t verdict);
    int   sx, sy, sz, total, c, x, y, z;
    logic mem, blocked;
    sx = extent(size_x_reg, MAX_X);
    sy = extent(size_y_reg, MAX_Y);
    sz = extent(size_z_reg, MAX_Z);
    total = sx * sy * sz;
    verdict = '0;
    if (arrived < total) begin
      // flush into an unfinished volume changes nothing
      if (item.func) return 1'b0;
      win_bits[arrived % WIN_DEPTH] =
        (item.voxel_label[LABEL_BITS-1:0] == sought_label[LABEL_BITS-1:0]);
    end
    arrived++;
    if (arrived <= sx * sy + sx + 1 || judged >= total) return 1'b0;

    c = judged;
    x = c % sx;
    y = (c / sx) % sy;
    z = c / (sx * sy);
    mem = win_bits[c % WIN_DEPTH];
    blocked = both_members(x, y, z, 1, 0, 0, sx, sy, sz) ||
              both_members(x, y, z, 0, 1, 0, sx, sy, sz) ||
              both_members(x, y, z, 0, 0, 1, sx, sy, sz) ||
              both_members(x, y, z, 1, 1, 0, sx, sy, sz) ||
              both_members(x, y, z, 1, -1, 0, sx, sy, sz) ||
              both_members(x, y, z, 0, 1, 1, sx, sy, sz) ||
              both_members(x, y, z, 0, 1, -1, sx, sy, sz) ||
              both_members(x, y, z, 1, 0, 1, sx, sy, sz) ||
              both_members(x, y, z, 1, 0, -1, sx, sy, sz);
    verdict.pos_x     = SIZE_W'(x + 1);
    verdict.pos_y     = SIZE_W'(y + 1);
    verdict.pos_z     = SIZE_W'(z + 1);
    verdict.is_member = mem;
    verdict.is_corner = mem && !blocked;
    verdict.last      = (c + 1 == total);

    judged++;
    if (judged >= total) begin
      judged = 0;
      arrived = 0;
    end
    return 1'b1;
  endfunction

  // Labels: the sought one with member_pct odds, else the previous label, a one-bit miss or noise
  function automatic logic [LABEL_W-1:0] pick_label(input int member_pct);
    logic [LABEL_W-1:0] v;
    v = LABEL_W'($urandom);
    if ($urandom_range(99) < member_pct) return sought_label;
    case ($urandom_range(2))
      0: v = prev_label;
      1: v = sought_label ^ (LABEL_W'(1) << $urandom_range(LABEL_W - 1));
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [SIZE_W-1:0] rand_extent();
    case ($urandom_range(19))
      0: return '0;
      1: return SIZE_W'($urandom_range(7, 16));
      default: return SIZE_W'($urandom_range(1, 5));
    endcase
  endfunction

  // Send one request; bursts of random length with random gaps in between.
  // Called and returns just after a falling edge.
  task automatic send_item(input logic func, input logic [LABEL_W-1:0] label);
    in_t  item;
    out_t verdict;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(99) < gap_odds) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    burst_left--;
    item.func = func;
    item.voxel_label = label;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (!(func && arrived < cur_total())) items_sent++;
    if (advance_window(item, verdict)) verdict_q.push_back(verdict);
    @(negedge clk);
  endtask

  // Stop sending and wait until every predicted result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write; bits above the field carry noise
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] data;
    data = $urandom;
    if (idx == REG_CELL_LABEL) data[LABEL_W-1:0] = value[LABEL_W-1:0];
    else data[SIZE_W-1:0] = value[SIZE_W-1:0];
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    case (idx)
      REG_CELL_LABEL: begin
        prev_label = sought_label;
        sought_label = data[LABEL_W-1:0];
      end
      REG_SIZE_X: begin size_x_reg = data[SIZE_W-1:0]; arrived = 0; judged = 0; end
      REG_SIZE_Y: begin size_y_reg = data[SIZE_W-1:0]; arrived = 0; judged = 0; end
      REG_SIZE_Z: begin size_z_reg = data[SIZE_W-1:0]; arrived = 0; judged = 0; end
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // APB read, compared with the predicted register value
  task automatic check_reg(input reg_idx_t idx);
    logic [CFG_DW-1:0] want;
    want = '0;
    case (idx)
      REG_CELL_LABEL: want[LABEL_W-1:0] = sought_label;
      REG_SIZE_X:     want[SIZE_W-1:0] = size_x_reg;
      REG_SIZE_Y:     want[SIZE_W-1:0] = size_y_reg;
      REG_SIZE_Z:     want[SIZE_W-1:0] = size_z_reg;
      default: ;
    endcase
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== want)
      flag_error($sformatf("register %s read: expected %h, got %h", idx.name(), want,
                           cfg_prdata));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_volume(input logic [SIZE_W-1:0] sx, sy, sz);
    drain_results();
    write_reg(REG_SIZE_X, CFG_DW'(sx));
    write_reg(REG_SIZE_Y, CFG_DW'(sy));
    write_reg(REG_SIZE_Z, CFG_DW'(sz));
  endtask

  // One volume of voxels then the drain. Noise adds ignored flushes during the
  // fill and voxel requests that act as flushes during the drain. At voxel
  // pause_at the block is drained and the label changed or the volume restarted.
  task automatic run_volume(input int member_pct, input int noise_pct, input int pause_at,
                            input pause_t pause_kind);
    int       total, lag, i;
    reg_idx_t idx;
    total = cur_total();
    lag = cur_lag();
    for (i = 0; i < total; i++) begin
      if (i == pause_at && pause_kind != PAUSE_NONE) begin
        drain_results();
        if (pause_kind == PAUSE_RESTART) begin
          // rewriting a size with its own value still restarts the volume
          idx = reg_idx_t'($urandom_range(1, 3));
          write_reg(idx, CFG_DW'((idx == REG_SIZE_X) ? size_x_reg :
                                 (idx == REG_SIZE_Y) ? size_y_reg : size_z_reg));
          return;
        end
        write_reg(REG_CELL_LABEL, $urandom_range(1, 65535));
      end
      if ($urandom_range(99) < noise_pct) send_item(1'b1, LABEL_W'($urandom));
      send_item(1'b0, pick_label(member_pct));
    end
    for (i = 0; i < lag; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(1'b0, LABEL_W'($urandom));
      else send_item(1'b1, LABEL_W'($urandom));
    end
  endtask

  // Reset values read back, then every register written and read back
  task automatic test_register_access();
    check_reg(REG_CELL_LABEL);
    check_reg(REG_SIZE_X);
    check_reg(REG_SIZE_Y);
    check_reg(REG_SIZE_Z);
    write_reg(REG_CELL_LABEL, 32'h0000_A5C3);
    write_reg(REG_SIZE_X, 32'd127);
    write_reg(REG_SIZE_Y, 32'd0);
    write_reg(REG_SIZE_Z, 32'd1);
    check_reg(REG_CELL_LABEL);
    check_reg(REG_SIZE_X);
    check_reg(REG_SIZE_Y);
    check_reg(REG_SIZE_Z);
  endtask

  // Short hand-made volumes covering the corner cases
  task automatic test_directed();
    gap_odds = 50;
    drain_results();
    write_reg(REG_CELL_LABEL, 32'h0000_FFFF);
    set_volume(7'd2, 7'd2, 7'd2);
    send_item(1'b1, 16'h1234);            // flush into an empty volume: ignored
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'h0000);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'hFFFE);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'hFFFF);
    send_item(1'b0, 16'h7FFF);
    send_item(1'b1, 16'h0000);
    send_item(1'b1, 16'hFFFF);
    send_item(1'b0, 16'hFFFF);            // voxel while draining acts as a flush
    repeat (4) send_item(1'b1, 16'h8001);
    send_item(1'b1, 16'h5555);            // past the end of volume: ignored
    // abandon a volume, then zero sizes give a single voxel
    repeat (3) send_item(1'b0, 16'hFFFF);
    drain_results();
    write_reg(REG_SIZE_X, 32'd0);
    write_reg(REG_SIZE_Y, 32'd0);
    write_reg(REG_SIZE_Z, 32'd0);
    send_item(1'b0, 16'hFFFF);
    repeat (3) send_item(1'b1, 16'h0000);
  endtask

  // Label change mid-volume: stored voxels keep their membership
  task automatic test_label_midvolume();
    gap_odds = 30;
    drain_results();
    write_reg(REG_CELL_LABEL, 32'h0000_00A5);
    set_volume(7'd3, 7'd3, 7'd2);
    run_volume(60, 0, 14, PAUSE_RELABEL);
    set_volume(7'd4, 7'd2, 7'd3);
    run_volume(50, 5, 5, PAUSE_RELABEL);
  endtask

  // Size write mid-volume restarts the scan
  task automatic test_size_restart();
    gap_odds = 30;
    set_volume(7'd4, 7'd3, 7'd2);
    run_volume(50, 5, 20, PAUSE_RESTART);
    run_volume(70, 5, -1, PAUSE_NONE);
  endtask

  // Full-width rows, columns and stacks, clamped sizes and a full-width
  // volume of two planes
  task automatic test_size_extremes();
    gap_odds = 20;
    set_volume(7'd127, 7'd1, 7'd1);
    run_volume(85, 5, -1, PAUSE_NONE);
    set_volume(7'd1, 7'd64, 7'd1);
    run_volume(85, 5, -1, PAUSE_NONE);
    set_volume(7'd0, 7'd0, 7'd64);
    run_volume(85, 5, -1, PAUSE_NONE);
    set_volume(7'd2, 7'd100, 7'd1);
    run_volume(80, 3, -1, PAUSE_NONE);
    gap_odds = 5;
    set_volume(7'd64, 7'd2, 7'd2);
    run_volume(90, 1, -1, PAUSE_NONE);
  endtask

  // Random small volumes with random labels, noise and mid-volume changes
  task automatic test_random_volumes();
    int     stop_at, pause_at, member_pct, noise_pct;
    pause_t pause_kind;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(9) < 3) begin
        drain_results();
        write_reg(REG_CELL_LABEL, $urandom_range(1, 65535));
      end
      set_volume(rand_extent(), rand_extent(), rand_extent());
      gap_odds = ($urandom_range(3) == 0) ? 0 : $urandom_range(20, 100);
      member_pct = $urandom_range(20, 95);
      noise_pct = ($urandom_range(9) < 7) ? 0 : $urandom_range(1, 10);
      pause_kind = PAUSE_NONE;
      pause_at = -1;
      case ($urandom_range(9))
        0: pause_kind = PAUSE_RELABEL;
        1: pause_kind = PAUSE_RESTART;
        default: ;
      endcase
      if (pause_kind != PAUSE_NONE) pause_at = $urandom_range(0, cur_total() - 1);
      run_volume(member_pct, noise_pct, pause_at, pause_kind);
    end
  endtask

  // Receiver stall pattern: modes of random length
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left = 0;
  int          run_left = 0;
  logic        run_level = 1'b0;

  always @(negedge clk) begin
    if (mode_left <= 0) begin
      stall_mode = stall_mode_t'($urandom_range(3));
      mode_left = $urandom_range(20, 300);
    end
    mode_left--;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(3) != 0);
      default: begin
        if (run_left <= 0) begin
          run_left = $urandom_range(1, 16);
          run_level = !run_level;
        end
        run_left--;
        out_stall <= run_level;
      end
    endcase
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin : check_result
    out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        flag_error($sformatf("result %0d with none expected: x=%0d y=%0d z=%0d", results_seen,
                             out_data.pos_x, out_data.pos_y, out_data.pos_z));
      end else begin
        want = verdict_q.pop_front();
        if (out_data.pos_x !== want.pos_x || out_data.pos_y !== want.pos_y ||
            out_data.pos_z !== want.pos_z || out_data.is_member !== want.is_member ||
            out_data.is_corner !== want.is_corner || out_data.last !== want.last)
          flag_error($sformatf(
            "result %0d: expected x=%0d y=%0d z=%0d mem=%b corner=%b last=%b, got x=%0d y=%0d z=%0d mem=%b corner=%b last=%b",
            results_seen, want.pos_x, want.pos_y, want.pos_z, want.is_member,
            want.is_corner, want.last, out_data.pos_x, out_data.pos_y, out_data.pos_z,
            out_data.is_member, out_data.is_corner, out_data.last));
      end
    end
  end

  // Watchdog on cycles with no request moving on either channel
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("voxel_corner_point_detect_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    rst_n       = 1'b0;
    for (int i = 0; i < WIN_DEPTH; i++) win_bits[i] = 1'b0;
    arrived      = 0;
    judged       = 0;
    sought_label = LABEL_W'(1);
    prev_label   = LABEL_W'(1);
    size_x_reg   = SIZE_W'(64);
    size_y_reg   = SIZE_W'(64);
    size_z_reg   = SIZE_W'(64);
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_access();
    test_directed();
    test_label_midvolume();
    test_size_restart();
    test_size_extremes();
    test_random_volumes();

    drain_results();
    repeat (10) @(negedge clk);
    error_count += verdict_q.size();
    if (error_count == 0) begin
      $display("voxel_corner_point_detect_unit_tb OK");
    end else begin
      $display("voxel_corner_point_detect_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
